>>> rtl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> rtl/lzw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzw_pkg
// Shared constants and types of the 12-bit LZW encoder.
// ----------------------------------------------------------------------------
package lzw_pkg;

  localparam int DICT_ENTRIES = 4096;
  localparam int NUM_CELLS    = 4;
  localparam int BANK_W       = $clog2(NUM_CELLS);
  localparam int BANK_DEPTH   = DICT_ENTRIES / NUM_CELLS;
  localparam int ROW_W        = $clog2(BANK_DEPTH);
  localparam int RC_W         = ROW_W + 1;
  localparam int FIRST_ROW    = 256 / NUM_CELLS;
  localparam int CODE_W       = 12;
  localparam int NFC_W        = 13;
  localparam int KEY_W        = CODE_W + 8;
  localparam int DR_W         = $clog2(NUM_CELLS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN,
    ST_EMIT
  } state_t;

  // search token handed along the cell chain
  typedef struct packed {
    logic              hit;
    logic [CODE_W-1:0] code;
  } tok_t;

  // control broadcast to every cell
  typedef struct packed {
    logic              rd_en;
    logic              clr;
    logic [ROW_W-1:0]  rd_row;
    logic [KEY_W-1:0]  key;
    logic [NFC_W-1:0]  nfc;
    logic              wr_en;
    logic [BANK_W-1:0] wr_bank;
    logic [ROW_W-1:0]  wr_row;
  } ctl_t;

  typedef struct packed {
    logic [7:0] data;
    logic       rlast;
    logic       send;
    logic       err;
  } res_t;

endpackage

>>> rtl/lzw_encoder_12bit_packed.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzw_encoder_12bit_packed
// LZW compressor, 12-bit codes packed two per three bytes, high bits first.
// ----------------------------------------------------------------------------
// Input channel in_*: one byte per transaction; in_tuser marks the first byte
// of a stream (dictionary restart), in_tlast the final byte (flushes the code).
// Output channel out_*: packed code bytes; out_tlast marks the last byte
// caused by one input, out_tuser carries stream end and dictionary overflow.
// The dictionary sits in a chain of four cells, each a bank of the table
// with its own comparator; a hit token travels down the chain one cell per
// cycle while all banks are read in lockstep, one row per cycle.
// Per input byte: a scan of the rows holding codes from 256 up to the next
// free code, a drain through the chain, then the result bytes (0 to 4).
// A first byte only restarts the dictionary, and flushes if also the last.
// One byte is worked at a time; in_tready is low until all its results are
// taken. A stalled receiver holds the current result steady.
// Reset stops the stream: bytes are dropped until a first byte arrives.
// The dictionary needs no clearing, the live range is tracked by the count.
// ----------------------------------------------------------------------------
module lzw_encoder_12bit_packed (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tuser,   // [0] first_byte
  input  logic       in_tlast,   // last_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [1:0] out_tuser,  // [0] stream_end, [1] overflow_error
  output logic       out_tlast   // run_last
);
  import lzw_pkg::*;

  state_t            state_r, state_nxt;
  logic [CODE_W-1:0] match_r, match_nxt;
  logic [NFC_W-1:0]  nfc_r, nfc_nxt;
  logic              hp_r, hp_nxt;
  logic [3:0]        pn_r, pn_nxt;
  logic              stop_r, stop_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic              last_r, last_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [RC_W-1:0]   row_r, row_nxt;
  logic [DR_W-1:0]   dcnt_r, dcnt_nxt;
  res_t              buf_r [4];
  res_t              buf_nxt [4];
  logic [2:0]        bn_r, bn_nxt;
  logic [1:0]        idx_r, idx_nxt;

  ctl_t              ctl;
  tok_t              tok [NUM_CELLS+1];
  logic [RC_W-1:0]   row_end;

  // result build
  logic [CODE_W-1:0] m;
  logic [NFC_W-1:0]  nfc_c;
  logic              hp, stop, miss;
  logic [3:0]        pn;
  logic [2:0]        n, nm1;
  res_t              rb [4];

  assign tok[0] = '0;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    lzw_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .bank_id (BANK_W'(i)),
      .ctl     (ctl),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  assign row_end = RC_W'((nfc_r + NFC_W'(NUM_CELLS - 1)) >> BANK_W);

  always_comb begin
    m     = match_r;
    nfc_c = nfc_r;
    hp    = hp_r;
    pn    = pn_r;
    stop  = stop_r;
    miss  = 1'b0;
    n     = 3'd0;
    nm1   = 3'd0;
    for (int i = 0; i < 4; i++) begin
      rb[i] = '0;
    end
    if (state_r == ST_DRAIN) begin
      if (tok[NUM_CELLS].hit) begin
        m = tok[NUM_CELLS].code;
      end else begin
        miss = 1'b1;
        if (hp_r) begin
          rb[0].data = {pn_r, match_r[11:8]};
          rb[1].data = match_r[7:0];
          n  = 3'd2;
          hp = 1'b0;
          pn = 4'd0;
        end else begin
          rb[0].data = match_r[11:4];
          n  = 3'd1;
          pn = match_r[3:0];
          hp = 1'b1;
        end
        nfc_c = nfc_r + NFC_W'(1);
        m     = {4'd0, byte_r};
      end
    end
    if (state_r == ST_DRAIN && nfc_c >= NFC_W'(DICT_ENTRIES)) begin
      rb[n[1:0]].err = 1'b1;
      n    = n + 3'd1;
      stop = 1'b1;
    end else if (last_r) begin
      if (hp) begin
        rb[n[1:0]].data = {pn, m[11:8]};
        rb[n[1:0] + 2'd1].data = m[7:0];
      end else begin
        rb[n[1:0]].data = m[11:4];
        rb[n[1:0] + 2'd1].data = {m[3:0], 4'd0};
      end
      rb[n[1:0] + 2'd1].send = 1'b1;
      n    = n + 3'd2;
      hp   = 1'b0;
      pn   = 4'd0;
      stop = 1'b1;
    end
    if (n != 3'd0) begin
      nm1 = n - 3'd1;
      rb[nm1[1:0]].rlast = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    match_nxt = match_r;
    nfc_nxt   = nfc_r;
    hp_nxt    = hp_r;
    pn_nxt    = pn_r;
    stop_nxt  = stop_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    key_nxt   = key_r;
    row_nxt   = row_r;
    dcnt_nxt  = dcnt_r;
    buf_nxt   = buf_r;
    bn_nxt    = bn_r;
    idx_nxt   = idx_r;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    ctl         = '0;
    ctl.rd_row  = row_r[ROW_W-1:0];
    ctl.key     = key_r;
    ctl.nfc     = nfc_r;
    ctl.wr_bank = nfc_r[BANK_W-1:0];
    ctl.wr_row  = nfc_r[BANK_W +: ROW_W];
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          byte_nxt = in_tdata;
          last_nxt = in_tlast;
          if (in_tuser) begin
            nfc_nxt   = NFC_W'(256);
            hp_nxt    = 1'b0;
            pn_nxt    = 4'd0;
            stop_nxt  = 1'b0;
            match_nxt = {4'd0, in_tdata};
            if (in_tlast) begin
              state_nxt = ST_FIN;
            end
          end else if (!stop_r) begin
            key_nxt   = {match_r, in_tdata};
            row_nxt   = RC_W'(FIRST_ROW);
            ctl.clr   = 1'b1;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (row_r != row_end) begin
          ctl.rd_en = 1'b1;
          row_nxt   = row_r + RC_W'(1);
        end else begin
          dcnt_nxt  = DR_W'(NUM_CELLS - 1);
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN, ST_FIN: begin
        if (state_r == ST_DRAIN && dcnt_r != '0) begin
          dcnt_nxt = dcnt_r - DR_W'(1);
        end else begin
          ctl.wr_en = miss;
          match_nxt = m;
          nfc_nxt   = nfc_c;
          hp_nxt    = hp;
          pn_nxt    = pn;
          stop_nxt  = stop;
          buf_nxt   = rb;
          bn_nxt    = n;
          idx_nxt   = 2'd0;
          state_nxt = (n != 3'd0) ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          idx_nxt = idx_r + 2'd1;
          if ({1'b0, idx_r} == bn_r - 3'd1) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      match_r <= '0;
      nfc_r   <= NFC_W'(256);
      hp_r    <= 1'b0;
      pn_r    <= 4'd0;
      stop_r  <= 1'b1;
      row_r   <= '0;
      dcnt_r  <= '0;
      bn_r    <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      match_r <= match_nxt;
      nfc_r   <= nfc_nxt;
      hp_r    <= hp_nxt;
      pn_r    <= pn_nxt;
      stop_r  <= stop_nxt;
      row_r   <= row_nxt;
      dcnt_r  <= dcnt_nxt;
      bn_r    <= bn_nxt;
      idx_r   <= idx_nxt;
    end
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    key_r  <= key_nxt;
    buf_r  <= buf_nxt;
  end

  assign out_tdata = buf_r[idx_r].data;
  assign out_tlast = buf_r[idx_r].rlast;
  assign out_tuser = {buf_r[idx_r].err, buf_r[idx_r].send};

endmodule

>>> rtl/lzw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lzw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/lzw_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzw_cell
// One dictionary bank with its comparator; ORs its hit into the passing token.
// ----------------------------------------------------------------------------
module lzw_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [lzw_pkg::BANK_W-1:0] bank_id,
  input  lzw_pkg::ctl_t             ctl,
  input  lzw_pkg::tok_t             tok_in,
  output lzw_pkg::tok_t             tok_out
);
  import lzw_pkg::*;

  logic [KEY_W-1:0]  rd_key;
  logic              valid_r;
  logic [ROW_W-1:0]  row_r;
  tok_t              tok_r;
  logic [NFC_W-1:0]  code_ext;
  logic              match;

  lzw_ram #(.WIDTH(KEY_W), .DEPTH(BANK_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ctl.wr_en && (ctl.wr_bank == bank_id)),
    .waddr (ctl.wr_row),
    .wdata (ctl.key),
    .raddr (ctl.rd_row),
    .rdata (rd_key)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl.rd_en;
    end
    row_r <= ctl.rd_row;
  end

  // code = row * cells + bank; only codes below next free are live
  assign code_ext = NFC_W'({row_r, bank_id});
  assign match    = valid_r && (rd_key == ctl.key) && (code_ext < ctl.nfc);

  // a hit, once seen, is held until the next search clears the chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else if (ctl.clr) begin
      tok_r <= '0;
    end else if (match) begin
      tok_r.hit  <= 1'b1;
      tok_r.code <= code_ext[CODE_W-1:0];
    end else if (tok_in.hit) begin
      tok_r <= tok_in;
    end
  end

  assign tok_out = tok_r;

endmodule

>>> rtl/lzw_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzw_chk
// Port-level checks of the LZW encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lzw_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       in_tuser,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [1:0] out_tuser,
  input logic       out_tlast
);

  // an overflow transaction closes the run and carries a zero byte
  `ASSERT_IMPL(a_err_last, clk, rst_n, out_tvalid && out_tuser[1], out_tlast && out_tdata == 8'd0 && !out_tuser[0])
  // stream end is always the final byte of its run
  `ASSERT_IMPL(a_end_last, clk, rst_n, out_tvalid && out_tuser[0], out_tlast)
  // no new byte is taken while results are pending
  `ASSERT_IMPL(a_one_item, clk, rst_n, out_tvalid, !in_tready)
  // a stalled result stays offered
  `ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

endmodule

bind lzw_encoder_12bit_packed lzw_chk u_lzw_chk (.*);
